/* src/ubds_pkg.sv */
// Shared types and constants for the baud divisor selector.
package ubds_pkg;

  localparam int BAUD_W          = 24;
  localparam int CLK_W           = 28;
  localparam int DIV_W           = 33;
  localparam int WORD_W          = 16;
  localparam int MANTISSA_BITS_D = 12;
  localparam logic [CLK_W-1:0] CLOCK_HZ_RST = 28'd16000000;
  localparam logic REG_CLOCK_HZ  = 1'b0;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LOW  = 2'd1,
    ST_HIGH = 2'd2
  } status_e;

  // one restoring-division step word
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] nq;
    logic [DIV_W-1:0] den;
  } div_word_t;

  // decision data carried alongside the rate check
  typedef struct packed {
    logic [BAUD_W-1:0] baud;
    status_e           st;
    logic              force8;
    logic [WORD_W-1:0] word16;
  } mid_t;

endpackage

/* src/ubds_div_cell.sv */
// One restoring division step with registered output.
module ubds_div_cell
  import ubds_pkg::*;
#(
  parameter int SW = 1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  div_word_t word_i,
  input  logic [SW-1:0] side_i,
  output logic      valid_o,
  output div_word_t word_o,
  output logic [SW-1:0] side_o
);

  logic [DIV_W:0] t;
  logic [DIV_W:0] diff;
  logic           ge;
  div_word_t      word_d;
  div_word_t      word_q;
  logic [SW-1:0]  side_q;
  logic           valid_q;

  always_comb begin
    t            = {word_i.rem, word_i.nq[DIV_W-1]};
    diff         = t - {1'b0, word_i.den};
    ge           = (t >= {1'b0, word_i.den});
    word_d.rem   = ge ? diff[DIV_W-1:0] : t[DIV_W-1:0];
    word_d.nq    = {word_i.nq[DIV_W-2:0], ge};
    word_d.den   = word_i.den;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
  assign side_o  = side_q;

endmodule

/* src/ubds_divider.sv */
// Pipelined divider: a chain of one-bit restoring cells.
module ubds_divider
  import ubds_pkg::*;
#(
  parameter int SW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DIV_W-1:0] den_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [DIV_W-1:0] quo_o,
  output logic [SW-1:0]    side_o
);

  div_word_t     chain [0:DIV_W];
  logic          vld   [0:DIV_W];
  logic [SW-1:0] side  [0:DIV_W];

  assign chain[0].rem = '0;
  assign chain[0].nq  = num_i;
  assign chain[0].den = den_i;
  assign vld[0]       = valid_i;
  assign side[0]      = side_i;

  for (genvar k = 0; k < DIV_W; k++) begin : g_cell
    ubds_div_cell #(.SW(SW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (vld[k]),
      .word_i  (chain[k]),
      .side_i  (side[k]),
      .valid_o (vld[k+1]),
      .word_o  (chain[k+1]),
      .side_o  (side[k+1])
    );
  end

  assign valid_o = vld[DIV_W];
  assign quo_o   = chain[DIV_W].nq;
  assign side_o  = side[DIV_W];

endmodule

/* src/uart_baud_divisor_select.sv */
// Top level: UART fractional baud divisor selection for x16 / x8 oversampling.
// Takes one baud-rate request per cycle and returns one result per request,
// in order. The rounded divisors come from two parallel 33-cell restoring
// divider chains, and the achieved rates of both settings from a second pair
// of 33-cell chains, followed by an output register. The whole pipeline
// holds while a result waits on m_axis_tready.
module uart_baud_divisor_select
  import ubds_pkg::*;
#(
  parameter int MANTISSA_BITS = MANTISSA_BITS_D
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] baud_rate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [15:0] divisor_word, [16] oversample_by_8,
                                      // [18:17] status, [23:19] zero
);

  localparam int MSB_LO = 4 + MANTISSA_BITS;

  logic [CLK_W-1:0]  clock_hz_q;
  logic              en;
  logic [31:0]       clk16;
  logic [BAUD_W-1:0] baud;

  logic [DIV_W-1:0]  num16, den16, num8, den8;
  logic              va, vb;
  logic [DIV_W-1:0]  i16, i8;
  logic [31+BAUD_W:0] side_a;
  logic              bzero;

  mid_t              mid_in, mid_out;
  logic [WORD_W-1:0] word8_in, word8_out;
  logic [DIV_W-1:0]  den_b16, den_b8, b16, b8;
  logic              vc, vd;
  logic [31:0]       clk_a;
  logic [BAUD_W-1:0] baud_a;
  logic              m16_zero, m8_zero, over;

  logic [DIV_W-1:0]  baud_x, e16, e8, thr;
  logic              keep16;
  logic [WORD_W-1:0] word_d, word_q;
  logic              x8_d, x8_q;
  status_e           st_d, st_q;
  logic              out_valid_q;

  // configuration
  assign pready = 1'b1;
  assign prdata = {{(32-CLK_W){1'b0}}, clock_hz_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= CLOCK_HZ_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CLOCK_HZ) begin
      clock_hz_q <= pwdata[CLK_W-1:0];
    end
  end

  // rounded divisors in sixteenths
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign baud          = s_axis_tdata[BAUD_W-1:0];
  assign clk16         = {clock_hz_q, 4'b0};
  assign num16 = {1'b0, clk16} + {{(DIV_W-BAUD_W-3){1'b0}}, baud, 3'b0};
  assign den16 = {{(DIV_W-BAUD_W-4){1'b0}}, baud, 4'b0};
  assign num8  = {1'b0, clk16} + {{(DIV_W-BAUD_W-2){1'b0}}, baud, 2'b0};
  assign den8  = {{(DIV_W-BAUD_W-3){1'b0}}, baud, 3'b0};

  ubds_divider #(.SW(32+BAUD_W)) u_div_i16 (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i (s_axis_tvalid),
    .num_i   (num16),
    .den_i   (den16),
    .side_i  ({clk16, baud}),
    .valid_o (va),
    .quo_o   (i16),
    .side_o  (side_a)
  );

  ubds_divider #(.SW(1)) u_div_i8 (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i (s_axis_tvalid),
    .num_i   (num8),
    .den_i   (den8),
    .side_i  (baud == '0),
    .valid_o (vb),
    .quo_o   (i8),
    .side_o  (bzero)
  );

  // range checks and achieved-rate denominators
  always_comb begin
    clk_a    = side_a[31+BAUD_W:BAUD_W];
    baud_a   = side_a[BAUD_W-1:0];
    m16_zero = (i16[DIV_W-1:4] == '0);
    m8_zero  = (i8[DIV_W-1:4] == '0);
    over     = (i16[DIV_W-1:MSB_LO] != '0) || (i8[DIV_W-1:MSB_LO] != '0);
    mid_in.baud   = baud_a;
    mid_in.force8 = m16_zero;
    mid_in.word16 = i16[WORD_W-1:0];
    if (bzero || over) begin
      mid_in.st = ST_LOW;
    end else if (m16_zero && m8_zero) begin
      mid_in.st = ST_HIGH;
    end else begin
      mid_in.st = ST_OK;
    end
    word8_in = {i8[15:4], 1'b0, i8[3:1]};
    den_b16  = {i16[DIV_W-5:0], 4'b0};
    den_b8   = {i8[DIV_W-4:1], 1'b0, 3'b0};
  end

  ubds_divider #(.SW($bits(mid_t))) u_div_b16 (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i (va && vb),
    .num_i   ({1'b0, clk_a}),
    .den_i   (den_b16),
    .side_i  (mid_in),
    .valid_o (vc),
    .quo_o   (b16),
    .side_o  (mid_out)
  );

  ubds_divider #(.SW(WORD_W)) u_div_b8 (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i (va && vb),
    .num_i   ({1'b0, clk_a}),
    .den_i   (den_b8),
    .side_i  (word8_in),
    .valid_o (vd),
    .quo_o   (b8),
    .side_o  (word8_out)
  );

  // setting choice
  always_comb begin
    baud_x = {{(DIV_W-BAUD_W){1'b0}}, mid_out.baud};
    e16    = (baud_x >= b16) ? (baud_x - b16) : (b16 - baud_x);
    e8     = (baud_x >= b8) ? (baud_x - b8) : (b8 - baud_x);
    thr    = {{(DIV_W-BAUD_W+6){1'b0}}, mid_out.baud[BAUD_W-1:7], 1'b0};
    keep16 = (e16 <= e8) || (e16 < thr);
    st_d   = mid_out.st;
    if (mid_out.st != ST_OK) begin
      word_d = '0;
      x8_d   = 1'b0;
    end else if (mid_out.force8 || !keep16) begin
      word_d = word8_out;
      x8_d   = 1'b1;
    end else begin
      word_d = mid_out.word16;
      x8_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vc && vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      word_q <= word_d;
      x8_q   <= x8_d;
      st_q   <= st_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, st_q, x8_q, word_q};

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && st_q != ST_OK |-> word_q == '0 && !x8_q)
    else $error("failed result carries a divisor");

  a_x8_bit3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && x8_q |-> !word_q[3])
    else $error("x8 divisor has fraction bit 3 set");

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va == vb && vc == vd)
    else $error("divider lanes out of step");

endmodule
